/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* rtl/teg_pkg.sv */
package teg_pkg;

  localparam int unsigned VecW     = 32;
  localparam int unsigned VecFrac  = 16;
  localparam int unsigned AreaW    = 48;
  localparam int          AreaFrac = 32;
  localparam int unsigned DivW     = 32;

  typedef enum logic {
    CMD_CURRENT = 1'b0,
    CMD_LOOP    = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    VTX_A    = 2'd0,
    VTX_B    = 2'd1,
    VTX_C    = 2'd2,
    VTX_NONE = 2'd3
  } pos_e;

endpackage

/* rtl/teg_sqrt_cell.sv */
module teg_sqrt_cell #(
  parameter int RW = 51,
  parameter int PW = 78
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [2*RW-1:0] s_i,
  input  logic [RW+1:0]   rem_i,
  input  logic [RW-1:0]   root_i,
  input  logic [PW-1:0]   pay_i,
  output logic            valid_o,
  output logic [2*RW-1:0] s_o,
  output logic [RW+1:0]   rem_o,
  output logic [RW-1:0]   root_o,
  output logic [PW-1:0]   pay_o
);

  logic            valid_q;
  logic [2*RW-1:0] s_q, s_d;
  logic [RW+1:0]   rem_q, rem_d, rem_sh, trial;
  logic [RW-1:0]   root_q, root_d;
  logic [PW-1:0]   pay_q;
  logic            ge;

  always_comb begin
    rem_sh = {rem_i[RW-1:0], s_i[2*RW-1 -: 2]};
    trial  = {root_i, 2'b01};
    ge     = rem_sh >= trial;
    rem_d  = ge ? rem_sh - trial : rem_sh;
    root_d = {root_i[RW-2:0], ge};
    s_d    = s_i << 2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q    <= s_d;
      rem_q  <= rem_d;
      root_q <= root_d;
      pay_q  <= pay_i;
    end
  end

  assign valid_o = valid_q;
  assign s_o     = s_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign pay_o   = pay_q;

endmodule

/* rtl/teg_div_cell.sv */
module teg_div_cell #(
  parameter int RW = 51,
  parameter int PW = 156
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [RW-1:0]                     div_i,
  input  logic [2:0][RW-1:0]                rem_i,
  input  logic [2:0][teg_pkg::DivW-1:0]     lo_i,
  input  logic [2:0][teg_pkg::DivW-1:0]     q_i,
  input  logic [PW-1:0]                     pay_i,
  output logic                              valid_o,
  output logic [RW-1:0]                     div_o,
  output logic [2:0][RW-1:0]                rem_o,
  output logic [2:0][teg_pkg::DivW-1:0]     lo_o,
  output logic [2:0][teg_pkg::DivW-1:0]     q_o,
  output logic [PW-1:0]                     pay_o
);
  import teg_pkg::*;

  logic                  valid_q;
  logic [RW-1:0]         div_q;
  logic [2:0][RW-1:0]    rem_q, rem_d;
  logic [2:0][DivW-1:0]  lo_q, lo_d, q_q, q_d;
  logic [PW-1:0]         pay_q;
  logic [RW:0]           rem_sh [3];
  logic [RW:0]           diff [3];
  logic [2:0]            ge;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rem_sh[k] = {rem_i[k], lo_i[k][DivW-1]};
      diff[k]   = rem_sh[k] - {1'b0, div_i};
      ge[k]     = rem_sh[k] >= {1'b0, div_i};
      rem_d[k]  = ge[k] ? diff[k][RW-1:0] : rem_sh[k][RW-1:0];
      q_d[k]    = {q_i[k][DivW-2:0], ge[k]};
      lo_d[k]   = lo_i[k] << 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_i;
      rem_q <= rem_d;
      lo_q  <= lo_d;
      q_q   <= q_d;
      pay_q <= pay_i;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;
  assign rem_o   = rem_q;
  assign lo_o    = lo_q;
  assign q_o     = q_q;
  assign pay_o   = pay_q;

endmodule

/* rtl/triangle_element_geometry_unit.sv */
// channel   | handshake                 | beat
// ----------+---------------------------+-------------------------------------------
// in        | in_valid_i / in_ready_o   | ax..cz, command, vertex_pos
// out       | out_valid_o / out_ready_i | tri_area, vec_x/y/z, degenerate, saturated
//
// One beat enters per cycle while in_ready_o is high.
// Pipeline: six front stages, one root cell per result bit, one prep stage,
// 32 divider cells, one output register.
// Reset clears only the valid bits of the stages and the output register.
// A stalled output beat holds every stage; in_ready_o drops only then.
`include "assert_macros.svh"

module triangle_element_geometry_unit #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]      ax_i,
  input  logic signed [COORD_WIDTH-1:0]      ay_i,
  input  logic signed [COORD_WIDTH-1:0]      az_i,
  input  logic signed [COORD_WIDTH-1:0]      bx_i,
  input  logic signed [COORD_WIDTH-1:0]      by_coord_i,
  input  logic signed [COORD_WIDTH-1:0]      bz_i,
  input  logic signed [COORD_WIDTH-1:0]      cx_i,
  input  logic signed [COORD_WIDTH-1:0]      cy_i,
  input  logic signed [COORD_WIDTH-1:0]      cz_i,
  input  logic                               command_i,
  input  logic [1:0]                         vertex_pos_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [teg_pkg::AreaW-1:0]          tri_area_o,
  output logic signed [teg_pkg::VecW-1:0]    vec_x_o,
  output logic signed [teg_pkg::VecW-1:0]    vec_y_o,
  output logic signed [teg_pkg::VecW-1:0]    vec_z_o,
  output logic                               degenerate_o,
  output logic                               saturated_o
);
  import teg_pkg::*;

  localparam int DW  = COORD_WIDTH + 1;
  localparam int MW  = 2 * DW;
  localparam int H   = DW;
  localparam int SQW = 2 * MW;
  localparam int SW  = SQW + 2;
  localparam int RW  = SW / 2;
  localparam int SP  = 3 * DW + 3;
  localparam int NW  = DW + FRAC_BITS + VecFrac;
  localparam int EW  = (NW > RW) ? NW + DivW : RW + DivW;
  localparam int AE  = AreaFrac - 1 - 2 * FRAC_BITS;
  localparam int AL  = (AE > 0) ? AE : 0;
  localparam int AR  = (AE < 0) ? -AE : 0;
  localparam int AW0 = RW + AL;
  localparam int AW  = (AW0 > AreaW + 1) ? AW0 : AreaW + 1;
  localparam int VK  = VecFrac - FRAC_BITS;
  localparam int SHL = (VK > 0) ? VK : 0;
  localparam int SHR = (VK < 0) ? -VK : 0;
  localparam int LW0 = DW + SHL + 1;
  localparam int LW  = (LW0 > VecW + 2) ? LW0 : VecW + 2;

  typedef struct packed {
    logic                       cmd;
    logic [1:0]                 pos;
    logic                       deg;
    logic                       sat_area;
    logic [AreaW-1:0]           area;
    logic [2:0]                 neg;
    logic [2:0]                 ovf;
    logic [2:0][VecW-1:0]       lvec;
    logic                       lsat;
  } dpay_t;

  localparam int DP = $bits(dpay_t);

  logic en;
  logic out_valid_q;
  logic [5:0] vld_q;

  assign en         = ~out_valid_q | out_ready_i;
  assign in_ready_o = en;

  // front stage: edges and selected difference
  logic signed [DW-1:0] a_s [3], b_s [3], c_s [3];
  logic signed [DW-1:0] u_d [3], v_d [3], e_d [3];
  logic signed [DW-1:0] u_q [3], v_q [3];
  logic [SP-1:0]        pay_d;
  logic [SP-1:0]        pay_q [6];

  always_comb begin
    a_s[0] = DW'(ax_i); a_s[1] = DW'(ay_i);       a_s[2] = DW'(az_i);
    b_s[0] = DW'(bx_i); b_s[1] = DW'(by_coord_i); b_s[2] = DW'(bz_i);
    c_s[0] = DW'(cx_i); c_s[1] = DW'(cy_i);       c_s[2] = DW'(cz_i);
    for (int k = 0; k < 3; k++) begin
      u_d[k] = a_s[k] - c_s[k];
      v_d[k] = b_s[k] - c_s[k];
      case (vertex_pos_i)
        VTX_A:   e_d[k] = c_s[k] - b_s[k];
        VTX_B:   e_d[k] = a_s[k] - c_s[k];
        VTX_C:   e_d[k] = b_s[k] - a_s[k];
        default: e_d[k] = '0;
      endcase
    end
    pay_d = {command_i, vertex_pos_i, e_d[2], e_d[1], e_d[0]};
  end

  // product, cross, square and sum stages
  logic signed [MW-1:0] p_d [6], p_q [6];
  logic signed [MW:0]   cr [3];
  logic [MW-1:0]        m_d [3], m_q [3];
  logic [MW-1:0]        hh_d [3], hl_d [3], ll_d [3], hh_q [3], hl_q [3], ll_q [3];
  logic [SQW-1:0]       sq_d [3], sq_q [3];
  logic [SW-1:0]        s_d, s_q;

  always_comb begin
    p_d[0] = u_q[1] * v_q[2];
    p_d[1] = u_q[2] * v_q[1];
    p_d[2] = u_q[2] * v_q[0];
    p_d[3] = u_q[0] * v_q[2];
    p_d[4] = u_q[0] * v_q[1];
    p_d[5] = u_q[1] * v_q[0];
    for (int k = 0; k < 3; k++) begin
      cr[k]   = p_q[2*k] - p_q[2*k+1];
      m_d[k]  = cr[k][MW] ? MW'(-cr[k]) : MW'(cr[k]);
      hh_d[k] = m_q[k][MW-1:H] * m_q[k][MW-1:H];
      hl_d[k] = m_q[k][MW-1:H] * m_q[k][H-1:0];
      ll_d[k] = m_q[k][H-1:0] * m_q[k][H-1:0];
      sq_d[k] = (SQW'(hh_q[k]) << (2 * H)) + (SQW'(hl_q[k]) << (H + 1)) + SQW'(ll_q[k]);
    end
    s_d = SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[4:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u_q        <= u_d;
      v_q        <= v_d;
      pay_q[0]   <= pay_d;
      p_q        <= p_d;
      m_q        <= m_d;
      hh_q       <= hh_d;
      hl_q       <= hl_d;
      ll_q       <= ll_d;
      sq_q       <= sq_d;
      s_q        <= s_d;
      for (int k = 1; k < 6; k++) begin
        pay_q[k] <= pay_q[k-1];
      end
    end
  end

  // root chain
  logic          rv   [RW+1];
  logic [SW-1:0] rs   [RW+1];
  logic [RW+1:0] rrem [RW+1];
  logic [RW-1:0] rrt  [RW+1];
  logic [SP-1:0] rpay [RW+1];

  assign rv[0]   = vld_q[5];
  assign rs[0]   = s_q;
  assign rrem[0] = '0;
  assign rrt[0]  = '0;
  assign rpay[0] = pay_q[5];

  for (genvar i = 0; i < RW; i++) begin : g_root
    teg_sqrt_cell #(.RW(RW), .PW(SP)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (rv[i]),
      .s_i     (rs[i]),
      .rem_i   (rrem[i]),
      .root_i  (rrt[i]),
      .pay_i   (rpay[i]),
      .valid_o (rv[i+1]),
      .s_o     (rs[i+1]),
      .rem_o   (rrem[i+1]),
      .root_o  (rrt[i+1]),
      .pay_o   (rpay[i+1])
    );
  end

  // prep stage: area, dividend split, loop vector
  logic [RW-1:0]          root;
  logic [AW-1:0]          area_w;
  logic signed [DW-1:0]   pd [3];
  logic [DW-1:0]          mg [3];
  logic [EW-1:0]          nx [3];
  logic signed [LW-1:0]   lx [3];
  logic [2:0]             lclip;
  dpay_t                  dp_d;
  logic [2:0][RW-1:0]     prem_d;
  logic [2:0][DivW-1:0]   plo_d;
  logic                   pv_q;
  logic [RW-1:0]          pr_q;
  logic [2:0][RW-1:0]     prem_q;
  logic [2:0][DivW-1:0]   plo_q;
  logic [DP-1:0]          dp_q;

  always_comb begin
    root   = rrt[RW];
    area_w = (AW'(root) << AL) >> AR;
    dp_d.cmd      = rpay[RW][SP-1];
    dp_d.pos      = rpay[RW][SP-2 -: 2];
    dp_d.deg      = area_w == '0;
    dp_d.sat_area = |area_w[AW-1:AreaW];
    dp_d.area     = dp_d.sat_area ? '1 : area_w[AreaW-1:0];
    for (int k = 0; k < 3; k++) begin
      pd[k]          = rpay[RW][k*DW +: DW];
      dp_d.neg[k]    = pd[k][DW-1];
      mg[k]          = pd[k][DW-1] ? DW'(-pd[k]) : DW'(pd[k]);
      nx[k]          = EW'(mg[k]) << (FRAC_BITS + VecFrac);
      dp_d.ovf[k]    = nx[k] >= (EW'(root) << DivW);
      prem_d[k]      = dp_d.ovf[k] ? '0 : RW'(nx[k] >> DivW);
      plo_d[k]       = nx[k][DivW-1:0];
      lx[k]          = (LW'(pd[k]) <<< SHL) >>> SHR;
      lclip[k]       = ~((&lx[k][LW-1:VecW-1]) | ~(|lx[k][LW-1:VecW-1]));
      dp_d.lvec[k]   = lclip[k] ? (lx[k][LW-1] ? {1'b1, {(VecW-1){1'b0}}}
                                               : {1'b0, {(VecW-1){1'b1}}})
                                : lx[k][VecW-1:0];
    end
    dp_d.lsat = |lclip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (en) begin
      pv_q <= rv[RW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pr_q   <= root;
      prem_q <= prem_d;
      plo_q  <= plo_d;
      dp_q   <= dp_d;
    end
  end

  // divider chain
  logic                  dv   [DivW+1];
  logic [RW-1:0]         ddiv [DivW+1];
  logic [2:0][RW-1:0]    drem [DivW+1];
  logic [2:0][DivW-1:0]  dlo  [DivW+1];
  logic [2:0][DivW-1:0]  dq   [DivW+1];
  logic [DP-1:0]         dpay [DivW+1];

  assign dv[0]   = pv_q;
  assign ddiv[0] = pr_q;
  assign drem[0] = prem_q;
  assign dlo[0]  = plo_q;
  assign dq[0]   = '0;
  assign dpay[0] = dp_q;

  for (genvar i = 0; i < DivW; i++) begin : g_div
    teg_div_cell #(.RW(RW), .PW(DP)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv[i]),
      .div_i   (ddiv[i]),
      .rem_i   (drem[i]),
      .lo_i    (dlo[i]),
      .q_i     (dq[i]),
      .pay_i   (dpay[i]),
      .valid_o (dv[i+1]),
      .div_o   (ddiv[i+1]),
      .rem_o   (drem[i+1]),
      .lo_o    (dlo[i+1]),
      .q_o     (dq[i+1]),
      .pay_o   (dpay[i+1])
    );
  end

  // output stage
  dpay_t                fp;
  logic [DivW-1:0]      q [3];
  logic [VecW-1:0]      lim [3];
  logic [2:0]           qsat;
  logic [VecW-1:0]      cur [3];
  logic [VecW-1:0]      res_d [3];
  logic                 sat_d;
  logic                 use_cur;
  logic                 use_loop;
  logic [AreaW-1:0]     area_q;
  logic [VecW-1:0]      res_q [3];
  logic                 deg_q;
  logic                 sat_q;

  always_comb begin
    fp       = dpay[DivW];
    use_loop = (fp.pos != VTX_NONE) && (fp.cmd == CMD_LOOP);
    use_cur  = (fp.pos != VTX_NONE) && (fp.cmd == CMD_CURRENT) && !fp.deg;
    for (int k = 0; k < 3; k++) begin
      q[k]    = dq[DivW][k];
      lim[k]  = fp.neg[k] ? {1'b1, {(VecW-1){1'b0}}} : {1'b0, {(VecW-1){1'b1}}};
      qsat[k] = fp.ovf[k] | (q[k] > lim[k]);
      cur[k]  = qsat[k] ? lim[k] : (fp.neg[k] ? VecW'(-q[k]) : VecW'(q[k]));
      if (use_loop) begin
        res_d[k] = fp.lvec[k];
      end else if (use_cur) begin
        res_d[k] = cur[k];
      end else begin
        res_d[k] = '0;
      end
    end
    sat_d = fp.sat_area | (use_loop & fp.lsat) | (use_cur & (|qsat));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv[DivW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      area_q <= fp.area;
      res_q  <= res_d;
      deg_q  <= fp.deg;
      sat_q  <= sat_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign tri_area_o   = area_q;
  assign vec_x_o      = res_q[0];
  assign vec_y_o      = res_q[1];
  assign vec_z_o      = res_q[2];
  assign degenerate_o = deg_q;
  assign saturated_o  = sat_q;

  `ASSERT_IMPLIES(a_deg_zero_area, clk_i, rst_ni, out_valid_o && degenerate_o, tri_area_o == '0)
  `ASSERT_IMPLIES(a_stall_cause, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)
  `ASSERT_NEXT(a_stall_keeps_beat, clk_i, rst_ni, !in_ready_o, out_valid_o)

endmodule
